// File: hdl/assert_macros.svh
// Assertion macros used by the top level of the triangle basis evaluator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// File: hdl/tlb_pkg.sv
// Shared constants, types and tables of the triangle basis evaluator.
`timescale 1ns / 1ps

package tlb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CW   = FRAC_BITS + 1;   // coordinate width
    localparam int LW   = FRAC_BITS + 2;   // barycentric coordinate width, signed
    localparam int FW   = FRAC_BITS + 4;   // factor width, signed
    localparam int M1W  = FRAC_BITS + 8;   // product of two factors
    localparam int M2W  = FRAC_BITS + 12;  // product of three factors
    localparam int M3W  = FRAC_BITS + 13;  // product of four factors
    localparam int TW   = FRAC_BITS + 14;  // derivative sum
    localparam int NW   = FRAC_BITS + 16;  // rounding numerator
    localparam int UW   = NW;              // divide-by-three operand
    localparam int OW   = 24;              // output fields
    localparam int IW   = 4;               // basis index
    localparam int KW   = 3;               // order register
    localparam int HALF = 1 << (FRAC_BITS - 1);

    localparam logic [CW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [UW-1:0] RECIP = UW'(((64'd1 << (UW + 1)) + 64'd1) / 64'd3);

    typedef enum logic [1:0] {
        SRC_L0,
        SRC_L1,
        SRC_L2,
        SRC_PAD
    } src_t;

    typedef struct packed {
        logic [4:0] den;
        logic [2:0] shift;
        logic       div3;
    } scale_t;

    typedef struct packed {
        logic [IW-1:0] idx;
        logic [KW-1:0] k;
        logic          last;
        scale_t        sc;
    } ctl_t;

    typedef struct packed {
        logic                 valid;
        logic [IW-1:0]        idx;
        logic [KW-1:0]        k;
        logic                 last;
        logic signed [LW-1:0] lam0;
        logic signed [LW-1:0] lam1;
        logic signed [LW-1:0] lam2;
    } s0_t;

    typedef struct packed {
        logic                  valid;
        ctl_t                  ctl;
        logic signed [M3W-1:0] prod;
        logic signed [TW-1:0]  tr;
        logic signed [TW-1:0]  ts;
    } s4_t;

    // Node exponents {i0, i1, i2}, one octal digit each.
    localparam logic [8:0] NODE_TAB [0:3][0:14] = '{
        '{9'o100, 9'o010, 9'o001, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000,
          9'o000, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000},
        '{9'o200, 9'o020, 9'o002, 9'o110, 9'o011, 9'o101, 9'o000, 9'o000,
          9'o000, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000},
        '{9'o300, 9'o030, 9'o003, 9'o210, 9'o120, 9'o021, 9'o012, 9'o102,
          9'o201, 9'o111, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000},
        '{9'o400, 9'o040, 9'o004, 9'o310, 9'o220, 9'o130, 9'o031, 9'o022,
          9'o013, 9'o103, 9'o202, 9'o301, 9'o211, 9'o121, 9'o112}
    };

    function automatic logic [KW-1:0] clamp_order(input logic [KW-1:0] k);
        logic [KW-1:0] res;
        res = k;
        if (k < 3'd1)
            res = 3'd1;
        else if (k > 3'd4)
            res = 3'd4;
        return res;
    endfunction

    function automatic logic [IW-1:0] count_of(input logic [KW-1:0] k);
        logic [IW-1:0] res;
        unique case (k)
            3'd1:    res = 4'd3;
            3'd2:    res = 4'd6;
            3'd3:    res = 4'd10;
            default: res = 4'd15;
        endcase
        return res;
    endfunction

    function automatic logic [4:0] fact_of(input logic [3:0] i);
        logic [4:0] res;
        case (i)
            4'd2:    res = 5'd2;
            4'd3:    res = 5'd6;
            4'd4:    res = 5'd24;
            default: res = 5'd1;
        endcase
        return res;
    endfunction

    // Rounding divides by 2*den: a shift, times one third when den has a factor three.
    function automatic scale_t den_scale(input logic [3:0] i0, input logic [3:0] i1,
                                         input logic [3:0] i2);
        logic [14:0] d;
        scale_t res;
        d = 15'(fact_of(i0)) * 15'(fact_of(i1)) * 15'(fact_of(i2));
        res.den = d[4:0];
        case (d)
            15'd2:   begin res.shift = 3'd2; res.div3 = 1'b0; end
            15'd4:   begin res.shift = 3'd3; res.div3 = 1'b0; end
            15'd6:   begin res.shift = 3'd2; res.div3 = 1'b1; end
            15'd24:  begin res.shift = 3'd4; res.div3 = 1'b1; end
            default: begin res.shift = 3'd1; res.div3 = 1'b0; end
        endcase
        return res;
    endfunction

    function automatic logic signed [OW-1:0] sat_out(input logic signed [NW-1:0] v);
        logic signed [OW-1:0] res;
        if (v > NW'(8388607))
            res = 24'sh7FFFFF;
        else if (v < -NW'(8388608))
            res = 24'sh800000;
        else
            res = v[OW-1:0];
        return res;
    endfunction

endpackage

// File: hdl/tlb_ifs.sv
// Valid/ready channel interfaces for the point input and the basis result output.
`timescale 1ns / 1ps

interface tlb_in_if import tlb_pkg::*; ();
    logic          valid;
    logic          ready;
    logic [CW-1:0] coord_r;
    logic [CW-1:0] coord_s;

    modport source (output valid, coord_r, coord_s, input ready);
    modport sink (input valid, coord_r, coord_s, output ready);
endinterface

interface tlb_out_if import tlb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [IW-1:0]        basis_index;
    logic signed [OW-1:0] basis_value;
    logic signed [OW-1:0] deriv_wrt_r;
    logic signed [OW-1:0] deriv_wrt_s;
    logic                 last_of_run;

    modport source (output valid, basis_index, basis_value, deriv_wrt_r, deriv_wrt_s,
                    last_of_run, input ready);
    modport sink (input valid, basis_index, basis_value, deriv_wrt_r, deriv_wrt_s,
                  last_of_run, output ready);
endinterface

// File: hdl/tlb_seq.sv
// Point intake and basis sequencer: issues one basis index per cycle for each point while en is high.
`timescale 1ns / 1ps

module tlb_seq import tlb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    tlb_in_if.sink        point,
    input  logic [KW-1:0] order,
    input  logic          en,
    output s0_t           s0
);

    logic                 busy_reg, busy_next;
    logic [IW-1:0]        cnt_reg, cnt_next;
    logic [KW-1:0]        k_reg;
    logic signed [LW-1:0] lam0_reg, lam1_reg, lam2_reg;
    logic                 last;
    logic                 take;
    logic [CW-1:0]        rc, sc;

    assign last = (cnt_reg == count_of(k_reg) - 4'd1);
    assign point.ready = en && (!busy_reg || last);
    assign take = point.valid && point.ready;

    assign rc = (point.coord_r > ONE) ? ONE : point.coord_r;
    assign sc = (point.coord_s > ONE) ? ONE : point.coord_s;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (en && busy_reg)
        begin
            if (last)
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg + 4'd1;
        end
        if (take)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            k_reg    <= clamp_order(order);
            lam0_reg <= $signed(LW'(ONE)) - $signed(LW'(rc)) - $signed(LW'(sc));
            lam1_reg <= $signed(LW'(rc));
            lam2_reg <= $signed(LW'(sc));
        end
    end

    assign s0.valid = busy_reg;
    assign s0.idx   = cnt_reg;
    assign s0.k     = k_reg;
    assign s0.last  = last;
    assign s0.lam0  = lam0_reg;
    assign s0.lam1  = lam1_reg;
    assign s0.lam2  = lam2_reg;

endmodule

// File: hdl/tlb_prod.sv
// Factor formation and the rounded product tree for value and derivative sums.
`timescale 1ns / 1ps

module tlb_prod import tlb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  s0_t  s0,
    output s4_t  s4
);

    // Stage 1: factors.
    logic                 s1_valid_reg;
    ctl_t                 s1_ctl_reg, s1_ctl_next;
    logic signed [FW-1:0] f1_reg [4];
    logic signed [FW-1:0] f1_next [4];
    src_t                 src1_reg [4];
    src_t                 src1_next [4];

    // Stage 2: pairwise products.
    logic                  s2_valid_reg;
    ctl_t                  s2_ctl_reg;
    logic signed [M1W-1:0] m01_reg, m02_reg, m12_reg;
    logic signed [FW-1:0]  f2s2_reg, f3s2_reg;
    src_t                  src2_reg [4];

    // Stage 3: leave-one-out products.
    logic                  s3_valid_reg;
    ctl_t                  s3_ctl_reg;
    logic signed [M2W-1:0] p_reg [4];
    logic signed [FW-1:0]  f3s3_reg;
    src_t                  src3_reg [4];

    // Stage 4: full product and derivative sums.
    logic                  s4_valid_reg;
    ctl_t                  s4_ctl_reg;
    logic signed [M3W-1:0] prod_reg;
    logic signed [TW-1:0]  tr_reg, ts_reg, tr_next, ts_next;

    logic signed [2*FW-1:0]    raw01, raw02, raw12;
    logic signed [M1W+FW-1:0]  raw0, raw1, raw2, raw3;
    logic signed [M2W+FW-1:0]  rawp;

    // Each product slot takes its factors in the node's order; spare slots hold one.
    always_comb
    begin
        logic [8:0]           node;
        logic [3:0]           i0, i1, i2, tt, jj;
        logic signed [FW-1:0] kl0, kl1, kl2, jone, ksg;
        node = NODE_TAB[2'(s0.k - 3'd1)][s0.idx];
        i0   = {1'b0, node[8:6]};
        i1   = {1'b0, node[5:3]};
        i2   = {1'b0, node[2:0]};
        ksg  = $signed(FW'({1'b0, s0.k}));
        kl0  = FW'(s0.lam0) * ksg;
        kl1  = FW'(s0.lam1) * ksg;
        kl2  = FW'(s0.lam2) * ksg;
        s1_ctl_next.idx  = s0.idx;
        s1_ctl_next.k    = s0.k;
        s1_ctl_next.last = s0.last;
        s1_ctl_next.sc   = den_scale(i0, i1, i2);
        for (int t = 0; t < 4; t++)
        begin
            tt = 4'(t);
            jj = '0;
            if (tt < i0)
            begin
                src1_next[t] = SRC_L0;
                jj = tt;
            end
            else if (tt < i0 + i1)
            begin
                src1_next[t] = SRC_L1;
                jj = tt - i0;
            end
            else if (tt < i0 + i1 + i2)
            begin
                src1_next[t] = SRC_L2;
                jj = tt - i0 - i1;
            end
            else
            begin
                src1_next[t] = SRC_PAD;
            end
            jone = $signed(FW'({jj[1:0], {FRAC_BITS{1'b0}}}));
            case (src1_next[t])
                SRC_L0:  f1_next[t] = kl0 - jone;
                SRC_L1:  f1_next[t] = kl1 - jone;
                SRC_L2:  f1_next[t] = kl2 - jone;
                default: f1_next[t] = $signed(FW'(ONE));
            endcase
        end
    end

    assign raw01 = f1_reg[0] * f1_reg[1];
    assign raw02 = f1_reg[0] * f1_reg[2];
    assign raw12 = f1_reg[1] * f1_reg[2];

    assign raw0 = m12_reg * f3s2_reg;
    assign raw1 = m02_reg * f3s2_reg;
    assign raw2 = m01_reg * f3s2_reg;
    assign raw3 = m01_reg * f2s2_reg;

    assign rawp = p_reg[3] * f3s3_reg;

    always_comb
    begin
        logic signed [TW-1:0] pe;
        tr_next = '0;
        ts_next = '0;
        for (int t = 0; t < 4; t++)
        begin
            pe = TW'(p_reg[t]);
            case (src3_reg[t])
                SRC_L0:
                begin
                    tr_next = tr_next - pe;
                    ts_next = ts_next - pe;
                end
                SRC_L1:  tr_next = tr_next + pe;
                SRC_L2:  ts_next = ts_next + pe;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= s0.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ctl_reg <= s1_ctl_next;
            f1_reg     <= f1_next;
            src1_reg   <= src1_next;

            s2_ctl_reg <= s1_ctl_reg;
            m01_reg    <= M1W'((raw01 + HALF) >>> FRAC_BITS);
            m02_reg    <= M1W'((raw02 + HALF) >>> FRAC_BITS);
            m12_reg    <= M1W'((raw12 + HALF) >>> FRAC_BITS);
            f2s2_reg   <= f1_reg[2];
            f3s2_reg   <= f1_reg[3];
            src2_reg   <= src1_reg;

            s3_ctl_reg <= s2_ctl_reg;
            p_reg[0]   <= M2W'((raw0 + HALF) >>> FRAC_BITS);
            p_reg[1]   <= M2W'((raw1 + HALF) >>> FRAC_BITS);
            p_reg[2]   <= M2W'((raw2 + HALF) >>> FRAC_BITS);
            p_reg[3]   <= M2W'((raw3 + HALF) >>> FRAC_BITS);
            f3s3_reg   <= f3s2_reg;
            src3_reg   <= src2_reg;

            s4_ctl_reg <= s3_ctl_reg;
            prod_reg   <= M3W'((rawp + HALF) >>> FRAC_BITS);
            tr_reg     <= tr_next;
            ts_reg     <= ts_next;
        end
    end

    assign s4.valid = s4_valid_reg;
    assign s4.ctl   = s4_ctl_reg;
    assign s4.prod  = prod_reg;
    assign s4.tr    = tr_reg;
    assign s4.ts    = ts_reg;

endmodule

// File: hdl/tlb_scale.sv
// Rounded division by the factorial product, saturation and the result register.
`timescale 1ns / 1ps

module tlb_scale import tlb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  s4_t       s4,
    tlb_out_if.source result
);

    // Lane 0 is the value, lane 1 d/dr, lane 2 d/ds.
    logic                 s5_valid_reg;
    ctl_t                 s5_ctl_reg;
    logic signed [NW-1:0] x5_reg [3];
    logic signed [NW-1:0] x5_next [3];
    logic [UW-1:0]        u5_reg [3];
    logic [UW-1:0]        u5_next [3];
    logic                 neg5_reg [3];
    logic                 neg5_next [3];

    logic                 s6_valid_reg;
    ctl_t                 s6_ctl_reg;
    logic signed [NW-1:0] x6_reg [3];
    logic [UW-2:0]        q6_reg [3];
    logic [UW-2:0]        q6_next [3];
    logic                 neg6_reg [3];

    logic                 out_valid_reg;
    logic [IW-1:0]        idx_reg;
    logic                 last_reg;
    logic signed [OW-1:0] y_reg [3];
    logic signed [OW-1:0] y_next [3];

    always_comb
    begin
        logic signed [NW-1:0] num [3];
        logic signed [NW-1:0] dsg, ksg;
        dsg = $signed(NW'({1'b0, s4.ctl.sc.den}));
        ksg = $signed(NW'({1'b0, s4.ctl.k}));
        num[0] = (NW'(s4.prod) <<< 1) + dsg;
        num[1] = ((NW'(s4.tr) * ksg) <<< 1) + dsg;
        num[2] = ((NW'(s4.ts) * ksg) <<< 1) + dsg;
        for (int l = 0; l < 3; l++)
        begin
            x5_next[l]   = num[l] >>> s4.ctl.sc.shift;
            neg5_next[l] = x5_next[l][NW-1];
            // Floor of a negative value over three is minus the ceiling of its magnitude.
            u5_next[l]   = neg5_next[l] ? UW'(-x5_next[l] + NW'(2)) : UW'(x5_next[l]);
        end
    end

    always_comb
    begin
        logic [2*UW-1:0] pr;
        for (int l = 0; l < 3; l++)
        begin
            pr = (2*UW)'(u5_reg[l]) * (2*UW)'(RECIP);
            q6_next[l] = pr[2*UW-1:UW+1];
        end
    end

    always_comb
    begin
        logic signed [NW-1:0] qs, y;
        for (int l = 0; l < 3; l++)
        begin
            qs = $signed({1'b0, q6_reg[l]});
            if (s6_ctl_reg.sc.div3)
                y = neg6_reg[l] ? -qs : qs;
            else
                y = x6_reg[l];
            y_next[l] = sat_out(y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s5_valid_reg  <= s4.valid;
            s6_valid_reg  <= s5_valid_reg;
            out_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_ctl_reg <= s4.ctl;
            x5_reg     <= x5_next;
            u5_reg     <= u5_next;
            neg5_reg   <= neg5_next;

            s6_ctl_reg <= s5_ctl_reg;
            x6_reg     <= x5_reg;
            q6_reg     <= q6_next;
            neg6_reg   <= neg5_reg;

            idx_reg    <= s6_ctl_reg.idx;
            last_reg   <= s6_ctl_reg.last;
            y_reg      <= y_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.basis_index = idx_reg;
    assign result.last_of_run = last_reg;
    assign result.basis_value = y_reg[0];
    assign result.deriv_wrt_r = y_reg[1];
    assign result.deriv_wrt_s = y_reg[2];

endmodule

// File: hdl/triangle_lagrange_basis_eval.sv
// Top level of the Lagrange basis evaluator on the reference triangle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// For each accepted point (r, s) the block emits one beat per basis function of the
// configured order: 3, 6, 10 or 15 beats for orders 1 to 4, in node order, the last
// one flagged by last_of_run. While the output is not stalled, the basis sequencer
// issues one basis function per cycle, and the next point is taken in the cycle that
// issues the previous point's last one; beats leave at one per cycle unless stalled.
// A point's first beat passes through the sequencer registers, four product stages,
// two division stages and the result register. A stall on the output freezes the
// whole pipeline. The user must write poly_order only while no point is in flight;
// the block does not enforce this. 0 acts as order 1 and 5 to 7 act as order 4.
module triangle_lagrange_basis_eval import tlb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic [KW-1:0] cfg_wr_data,
    tlb_in_if.sink        point,
    tlb_out_if.source     result
);

    logic [KW-1:0] poly_order_reg;
    logic          en;
    s0_t           s0;
    s4_t           s4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            poly_order_reg <= 3'd1;
        else if (cfg_wr_en)
            poly_order_reg <= cfg_wr_data;
    end

    assign en = !result.valid || result.ready;

    tlb_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .point (point),
        .order (poly_order_reg),
        .en    (en),
        .s0    (s0)
    );

    tlb_prod u_prod
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .s0    (s0),
        .s4    (s4)
    );

    tlb_scale u_scale
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .s4     (s4),
        .result (result)
    );

    `ASSERT_NEXT(a_take_starts_run, point.valid && point.ready, s0.valid && s0.idx == 4'd0)
    `ASSERT_IMPLIES(a_ready_needs_room, point.ready, en)
    `ASSERT_NEXT(a_run_continues, s0.valid && en && !s0.last, s0.valid)

endmodule
